@@ hw/rtl/agf_pkg.sv @@
// shared constants, command codes, field functions and the s-box table for the gf(2^8) unit
package agf_pkg;

    // command codes
    localparam logic [2:0] CMD_XTIME    = 3'd0;
    localparam logic [2:0] CMD_MUL      = 3'd1;
    localparam logic [2:0] CMD_INV      = 3'd2;
    localparam logic [2:0] CMD_SBOX     = 3'd3;
    localparam logic [2:0] CMD_INV_SBOX = 3'd4;

    // field and affine constants
    localparam logic [7:0] GF_REDUCE      = 8'h1b;
    localparam logic [7:0] INV_SBOX_CONST = 8'h05;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_cmd;

    // forward s-box, affine map applied to the field inverse
    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // multiply by x with reduction
    function automatic t_byte gf_xtime(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
    endfunction

    // shift-and-add field multiply, eight narrow steps
    function automatic t_byte gf_mul(input t_byte x, input t_byte y);
        t_byte acc;
        t_byte p;
        acc = 8'h00;
        p   = x;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                acc = acc ^ p;
            end
            p = gf_xtime(p);
        end
        return acc;
    endfunction

    // inverse of the s-box affine map
    function automatic t_byte inv_affine(input t_byte v);
        t_byte r1;
        t_byte r3;
        t_byte r6;
        r1 = {v[6:0], v[7]};
        r3 = {v[4:0], v[7:5]};
        r6 = {v[1:0], v[7:2]};
        return r1 ^ r3 ^ r6 ^ INV_SBOX_CONST;
    endfunction

endpackage

@@ hw/rtl/agf_if.sv @@
// request and response channel interfaces of the gf(2^8) unit
interface agf_req_if;
    logic              valid;
    logic              ready;
    agf_pkg::t_cmd     command;
    agf_pkg::t_byte    operand_a;
    agf_pkg::t_byte    operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

interface agf_rsp_if;
    logic              valid;
    logic              ready;
    agf_pkg::t_byte    result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

@@ hw/rtl/agf_sbox_rom.sv @@
// forward s-box lookup table
module agf_sbox_rom (
    input  agf_pkg::t_byte i_addr,
    output agf_pkg::t_byte o_data
);

    // constant table read
    assign o_data = agf_pkg::SBOX[i_addr];

endmodule

@@ hw/rtl/agf_datapath.sv @@
// combinational gf(2^8) datapath: xtime, multiply, inverse and both s-box directions
module agf_datapath (
    input  agf_pkg::t_cmd  i_command,
    input  agf_pkg::t_byte i_operand_a,
    input  agf_pkg::t_byte i_operand_b,
    output agf_pkg::t_byte o_result
);

    agf_pkg::t_byte sbox_a;
    agf_pkg::t_byte inv_in;
    agf_pkg::t_byte sbox_inv_in;
    agf_pkg::t_byte inv_a;
    agf_pkg::t_byte inv_sbox_a;

    // forward s-box of operand a; inverse falls out by undoing the affine map
    agf_sbox_rom u_rom_fwd (
        .i_addr (i_operand_a),
        .o_data (sbox_a)
    );
    assign inv_a = agf_pkg::inv_affine(sbox_a);

    // inverse s-box: inverse affine, then field inverse through the same table
    assign inv_in = agf_pkg::inv_affine(i_operand_a);
    agf_sbox_rom u_rom_inv (
        .i_addr (inv_in),
        .o_data (sbox_inv_in)
    );
    assign inv_sbox_a = agf_pkg::inv_affine(sbox_inv_in);

    // command select
    always_comb begin
        unique case (i_command)
            agf_pkg::CMD_XTIME:    o_result = agf_pkg::gf_xtime(i_operand_a);
            agf_pkg::CMD_MUL:      o_result = agf_pkg::gf_mul(i_operand_a, i_operand_b);
            agf_pkg::CMD_INV:      o_result = inv_a;
            agf_pkg::CMD_SBOX:     o_result = sbox_a;
            agf_pkg::CMD_INV_SBOX: o_result = inv_sbox_a;
            default:               o_result = 8'h00;
        endcase
    end

endmodule

@@ hw/rtl/aes_gf256_arith_unit.sv @@
// top level of the gf(2^8) arithmetic unit with input and result registers
//
// Byte-wide arithmetic over the AES field, polynomial x^8+x^4+x^3+x+1.
// Request channel i_req (sink): command, operand_a, operand_b. Commands are
// xtime, multiply, inverse (zero maps to zero), forward s-box and inverse
// s-box; undefined commands return zero. Response channel o_rsp (source):
// result_byte, one per request, in request order.
// A request accepted on i_req is held in the input register, then in the result
// register, which drives o_rsp. Throughput: one request per cycle;
// both stages advance together whenever the result register is empty or
// being taken, so the two table lookups and the multiplier sit in a single
// register-to-register path.
// When the receiver stalls, the held result stays on o_rsp, the input
// register may still fill, and i_req.ready drops once both stages are full.
// Reset (i_rst_n low, synchronous) empties both stages; the command, operand
// and result data registers are not reset.
module aes_gf256_arith_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    agf_req_if.sink   i_req,
    agf_rsp_if.source o_rsp
);

    logic           r_in_valid;
    agf_pkg::t_cmd  r_command;
    agf_pkg::t_byte r_operand_a;
    agf_pkg::t_byte r_operand_b;
    logic           r_out_valid;
    agf_pkg::t_byte r_result;
    agf_pkg::t_byte n_result;
    logic           advance;

    // pipeline moves when the result register can take a new value
    assign advance     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_command   <= i_req.command;
            r_operand_a <= i_req.operand_a;
            r_operand_b <= i_req.operand_b;
        end
    end

    // field arithmetic
    agf_datapath u_datapath (
        .i_command   (r_command),
        .i_operand_a (r_operand_a),
        .i_operand_b (r_operand_b),
        .o_result    (n_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_byte = r_result;

`ifndef ASSERT_OFF
    // a stage holding a request hands it on when the pipeline moves
    a_stage_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("request lost between input and result register");

    // both stages full means the request channel is closed
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request accepted with both stages full");

    // undefined commands give zero
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_command != agf_pkg::CMD_XTIME
            && r_command != agf_pkg::CMD_MUL && r_command != agf_pkg::CMD_INV
            && r_command != agf_pkg::CMD_SBOX && r_command != agf_pkg::CMD_INV_SBOX)
        |=> (r_result == 8'h00))
        else $error("undefined command gave a nonzero result");

    // xtime without carry is a plain shift
    a_xtime_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_command == agf_pkg::CMD_XTIME && !r_operand_a[7])
        |=> (r_result == {$past(r_operand_a[6:0]), 1'b0}))
        else $error("xtime result wrong");
`endif

endmodule
